@@ rtl/iir3_pkg.sv @@
// Shared types and constants of the three-axis IIR low-pass filter.
package iir3_pkg;

    localparam int HIST_W     = 32;
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 30;
    localparam int PROD_W     = HIST_W + COEF_W;
    localparam int ACC_W      = 36;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_FEEDBACK_ONE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_FEEDBACK_TWO = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_INPUT        = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_FEEDBACK_ONE_RST = 32'sd2071735500;
    localparam logic signed [COEF_W-1:0] COEF_FEEDBACK_TWO_RST = -32'sd1000494913;
    localparam logic signed [COEF_W-1:0] COEF_INPUT_RST        = 32'sd2501237;

    localparam logic signed [ACC_W-1:0] ACC_HIST_MAX = 36'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_HIST_MIN = -36'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB1,
        ST_FB2,
        ST_IN,
        ST_SUM
    } seq_state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] feedback_one;
        logic signed [COEF_W-1:0] feedback_two;
        logic signed [COEF_W-1:0] input_gain;
    } coef_set_t;

    typedef struct packed {
        seq_state_t state;
        logic       load;
        logic       finish;
        logic       prime;
    } lane_ctrl_t;

endpackage

@@ rtl/iir3_lane.sv @@
// One axis of the filter: shared multiplier, accumulator and two-entry history.
module iir3_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  iir3_pkg::lane_ctrl_t                ctrl,
    input  iir3_pkg::coef_set_t                 coefs,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic signed [iir3_pkg::HIST_W-1:0]  hist_next
);

    localparam int HIST_FRAC = iir3_pkg::HIST_W - SAMPLE_BITS;
    localparam int IN_SHIFT  = iir3_pkg::COEF_FRAC - HIST_FRAC;

    logic signed [SAMPLE_BITS-1:0]          x_reg;
    logic signed [iir3_pkg::HIST_W-1:0]     y1_reg;
    logic signed [iir3_pkg::HIST_W-1:0]     y2_reg;
    logic signed [iir3_pkg::PROD_W-1:0]     prod_reg;
    logic signed [iir3_pkg::ACC_W-1:0]      acc_reg;

    logic signed [iir3_pkg::HIST_W-1:0]     x_ext;
    logic signed [iir3_pkg::HIST_W-1:0]     mult_a;
    logic signed [iir3_pkg::COEF_W-1:0]     mult_b;
    logic signed [iir3_pkg::PROD_W-1:0]     prod_next;
    logic signed [iir3_pkg::ACC_W-1:0]      term_fb;
    logic signed [iir3_pkg::ACC_W-1:0]      term_in;
    logic signed [iir3_pkg::ACC_W-1:0]      sum;
    logic signed [iir3_pkg::HIST_W-1:0]     sat_val;
    logic signed [iir3_pkg::HIST_W-1:0]     prime_val;

    assign x_ext = iir3_pkg::HIST_W'(x_reg);

    // One product per cycle: y1*c1, then y2*c2, then x*b.
    always_comb
    begin
        unique case (ctrl.state)
            iir3_pkg::ST_FB1:
            begin
                mult_a = y1_reg;
                mult_b = coefs.feedback_one;
            end
            iir3_pkg::ST_FB2:
            begin
                mult_a = y2_reg;
                mult_b = coefs.feedback_two;
            end
            default:
            begin
                mult_a = x_ext;
                mult_b = coefs.input_gain;
            end
        endcase
    end

    assign prod_next = mult_a * mult_b;

    // Truncating shifts; the feedback and input products use different scales.
    assign term_fb = iir3_pkg::ACC_W'(prod_reg >>> iir3_pkg::COEF_FRAC);
    assign term_in = iir3_pkg::ACC_W'(prod_reg >>> IN_SHIFT);
    assign sum     = acc_reg + term_in;

    always_comb
    begin
        priority if (sum > iir3_pkg::ACC_HIST_MAX)
            sat_val = iir3_pkg::ACC_HIST_MAX[iir3_pkg::HIST_W-1:0];
        else if (sum < iir3_pkg::ACC_HIST_MIN)
            sat_val = iir3_pkg::ACC_HIST_MIN[iir3_pkg::HIST_W-1:0];
        else
            sat_val = sum[iir3_pkg::HIST_W-1:0];
    end

    assign prime_val = x_ext <<< HIST_FRAC;
    assign hist_next = ctrl.prime ? prime_val : sat_val;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            x_reg <= sample;

        unique case (ctrl.state)
            iir3_pkg::ST_FB1:
            begin
                prod_reg <= prod_next;
            end
            iir3_pkg::ST_FB2:
            begin
                prod_reg <= prod_next;
                acc_reg  <= term_fb;
            end
            iir3_pkg::ST_IN:
            begin
                prod_reg <= prod_next;
                acc_reg  <= acc_reg + term_fb;
            end
            iir3_pkg::ST_SUM:
            begin
                if (ctrl.finish)
                begin
                    y2_reg <= ctrl.prime ? prime_val : y1_reg;
                    y1_reg <= hist_next;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/iir3_merge.sv @@
// Rounds and saturates the lane results and holds the packed output transaction.
module iir3_merge #(
    parameter  int AXES        = 3,
    parameter  int SAMPLE_BITS = 16,
    localparam int DATA_W      = ((AXES * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   finish,
    input  logic [AXES-1:0][iir3_pkg::HIST_W-1:0]  hist,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic [DATA_W-1:0]                      m_tdata
);

    localparam int RND_W     = iir3_pkg::HIST_W + 1;
    localparam int HIST_FRAC = iir3_pkg::HIST_W - SAMPLE_BITS;
    localparam logic signed [RND_W-1:0] HALF =
        (HIST_FRAC > 0) ? (33'sd1 <<< (HIST_FRAC - 1)) : 33'sd0;
    localparam logic signed [RND_W-1:0] SMAX = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
    localparam logic signed [RND_W-1:0] SMIN = -SMAX - 33'sd1;

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        logic signed [RND_W-1:0] wide;
        logic signed [RND_W-1:0] rnd;
        data_next = '0;
        for (int i = 0; i < AXES; i++)
        begin
            wide = RND_W'(signed'(hist[i])) + HALF;
            rnd  = wide >>> HIST_FRAC;
            priority if (rnd > SMAX)
                rnd = SMAX;
            else if (rnd < SMIN)
                rnd = SMIN;
            data_next[i*SAMPLE_BITS +: SAMPLE_BITS] = rnd[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (finish)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
            data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

@@ rtl/three_axis_iir_lowpass.sv @@
// An accepted input transaction passes through the input buffer, the sequencer steps
// FB1, FB2, IN and SUM, and the output register. Each lane runs its three products
// through one shared 32x32 multiplier, then sums and updates its history in the SUM step.
// A one-entry input buffer and the output register let the next transaction enter
// and the last result wait while a sample is in flight.
// Reset loads the default coefficients and clears the primed flag; the first sample
// after reset seeds the history and is passed through unchanged.
module three_axis_iir_lowpass #(
    parameter  int AXES        = 3,
    parameter  int SAMPLE_BITS = 16,
    localparam int DATA_W      = ((AXES * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Input stream; tdata from the lowest bit up: sample_x, sample_y, sample_z,
    // zero padding to a whole byte.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [DATA_W-1:0]                   s_tdata,

    // Output stream; tdata from the lowest bit up: filtered_x, filtered_y,
    // filtered_z, zero padding to a whole byte.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [DATA_W-1:0]                   m_tdata,

    // Coefficient write port: 0 feedback one, 1 feedback two, 2 input gain.
    input  logic                                cfg_wen,
    input  logic [iir3_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [iir3_pkg::COEF_W-1:0]         cfg_wdata
);

    localparam int SAMPLES_W = AXES * SAMPLE_BITS;

    iir3_pkg::coef_set_t    coef_reg;
    logic                   in_full_reg;
    logic [SAMPLES_W-1:0]   in_data_reg;
    logic                   primed_reg;
    logic                   prime_item_reg;
    iir3_pkg::seq_state_t   state_reg;
    iir3_pkg::seq_state_t   state_next;

    logic                   out_free;
    logic                   load;
    logic                   finish;
    iir3_pkg::lane_ctrl_t   lane_ctrl;
    logic [AXES-1:0][iir3_pkg::HIST_W-1:0] lane_hist;

    // Coefficient registers. Writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.feedback_one <= iir3_pkg::COEF_FEEDBACK_ONE_RST;
            coef_reg.feedback_two <= iir3_pkg::COEF_FEEDBACK_TWO_RST;
            coef_reg.input_gain   <= iir3_pkg::COEF_INPUT_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                iir3_pkg::CFG_COEF_FEEDBACK_ONE: coef_reg.feedback_one <= cfg_wdata;
                iir3_pkg::CFG_COEF_FEEDBACK_TWO: coef_reg.feedback_two <= cfg_wdata;
                iir3_pkg::CFG_COEF_INPUT:        coef_reg.input_gain   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // The output register is free when it is empty or being drained this cycle.
    assign out_free = !m_tvalid || m_tready;

    // Next-state logic of the per-sample sequencer shared by all lanes.
    always_comb
    begin
        unique case (state_reg)
            iir3_pkg::ST_IDLE: state_next = in_full_reg ? iir3_pkg::ST_FB1 : iir3_pkg::ST_IDLE;
            iir3_pkg::ST_FB1:  state_next = iir3_pkg::ST_FB2;
            iir3_pkg::ST_FB2:  state_next = iir3_pkg::ST_IN;
            iir3_pkg::ST_IN:   state_next = iir3_pkg::ST_SUM;
            iir3_pkg::ST_SUM:
            begin
                if (!out_free)
                    state_next = iir3_pkg::ST_SUM;
                else if (in_full_reg)
                    state_next = iir3_pkg::ST_FB1;
                else
                    state_next = iir3_pkg::ST_IDLE;
            end
            default:           state_next = iir3_pkg::ST_IDLE;
        endcase
    end

    // Output logic: a buffered sample moves into the lanes when the sequencer is
    // idle or finishing, and a sum step completes only when the output can take it.
    always_comb
    begin
        unique case (state_reg)
            iir3_pkg::ST_IDLE:
            begin
                load   = in_full_reg;
                finish = 1'b0;
            end
            iir3_pkg::ST_SUM:
            begin
                load   = in_full_reg && out_free;
                finish = out_free;
            end
            default:
            begin
                load   = 1'b0;
                finish = 1'b0;
            end
        endcase
        s_tready         = !in_full_reg || load;
        lane_ctrl.state  = state_reg;
        lane_ctrl.load   = load;
        lane_ctrl.finish = finish;
        lane_ctrl.prime  = prime_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= iir3_pkg::ST_IDLE;
            in_full_reg    <= 1'b0;
            primed_reg     <= 1'b0;
            prime_item_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_tvalid && s_tready)
                in_full_reg <= 1'b1;
            else if (load)
                in_full_reg <= 1'b0;
            if (load)
            begin
                primed_reg     <= 1'b1;
                prime_item_reg <= !primed_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata[SAMPLES_W-1:0];
    end

    // One lane per axis, all driven by the same sequencer.
    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        iir3_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk       (clk),
            .ctrl      (lane_ctrl),
            .coefs     (coef_reg),
            .sample    (in_data_reg[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .hist_next (lane_hist[g])
        );
    end

    iir3_merge #(
        .AXES        (AXES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .finish   (finish),
        .hist     (lane_hist),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // A new result appears only right after a completed sum step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == iir3_pkg::ST_SUM)
        else $error("output valid rose without a completed sum step");

    // A stalled output holds the sequencer in the sum step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iir3_pkg::ST_SUM && m_tvalid && !m_tready)
            |=> state_reg == iir3_pkg::ST_SUM)
        else $error("sum step left while the output was stalled");

    // Only the first sample after reset takes the priming path.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && primed_reg) |=> !prime_item_reg)
        else $error("priming repeated after the first sample");

endmodule
